[design/crbct_pkg.sv]
package crbct_pkg;

  localparam int CACHE_SLOTS = 64;
  localparam int IDX_W       = $clog2(CACHE_SLOTS);
  localparam int SLOT_W      = 6;
  localparam int SECT_W      = 32;
  localparam int PIN_W       = 8;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  typedef enum logic [1:0] {
    KIND_ACCESS  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_WBEHIND = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ALLPINNED = 2'd1,
    ST_UNCACHED  = 2'd2,
    ST_PINSAT    = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [SECT_W-1:0]  sector;
    logic               mark_dirty;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               fill_needed;
    logic               writeback_valid;
    logic [SECT_W-1:0]  writeback_sector;
    status_t            status;
    logic               last;
  } out_rsp_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_RESOLVE,
    FSM_SWEEP,
    FSM_VICTIM,
    FSM_SCAN,
    FSM_WB,
    FSM_ZERO
  } fsm_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOOKUP,
    OP_HIT,
    OP_REL,
    OP_FAIL,
    OP_FILL,
    OP_SWEEP_START,
    OP_SWEEP,
    OP_VICTIM,
    OP_SCAN_STEP,
    OP_WB,
    OP_ZERO
  } dp_op_t;

  typedef struct packed {
    logic is_access;
    logic in_scan;
    logic is_hit;
    logic free_any;
    logic unpinned_any;
    logic sweep_found;
    logic cur_dirty;
    logic idx_last;
    logic more_dirty;
    logic out_free;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] lowest_set(input logic [CACHE_SLOTS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(CACHE_SLOTS - 1)) r = '0;
    else r = i + 1'b1;
    return r;
  endfunction

endpackage

[design/crbct_ctrl.sv]
module crbct_ctrl import crbct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t st,
  output logic     in_ready,
  output dp_op_t   op
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FSM_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:    if (in_valid) state_nxt = st.in_scan ? FSM_SCAN : FSM_LOOKUP;
      FSM_LOOKUP:  state_nxt = FSM_RESOLVE;
      FSM_RESOLVE: begin
        if (st.out_free) begin
          if (st.is_access && !st.is_hit && !st.free_any && st.unpinned_any)
            state_nxt = FSM_SWEEP;
          else
            state_nxt = FSM_IDLE;
        end
      end
      FSM_SWEEP:   if (st.sweep_found) state_nxt = FSM_VICTIM;
      FSM_VICTIM:  if (st.out_free) state_nxt = FSM_IDLE;
      FSM_SCAN: begin
        if (st.cur_dirty)     state_nxt = FSM_WB;
        else if (st.idx_last) state_nxt = FSM_ZERO;
      end
      FSM_WB:      if (st.out_free) state_nxt = st.more_dirty ? FSM_SCAN : FSM_IDLE;
      FSM_ZERO:    if (st.out_free) state_nxt = FSM_IDLE;
      default:     state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      FSM_LOOKUP:  op = OP_LOOKUP;
      FSM_RESOLVE: begin
        if (st.out_free) begin
          priority if (st.is_hit)        op = st.is_access ? OP_HIT : OP_REL;
          else if (!st.is_access)        op = OP_FAIL;
          else if (st.free_any)          op = OP_FILL;
          else if (!st.unpinned_any)     op = OP_FAIL;
          else                           op = OP_SWEEP_START;
        end
      end
      FSM_SWEEP:   if (!st.sweep_found) op = OP_SWEEP;
      FSM_VICTIM:  if (st.out_free) op = OP_VICTIM;
      FSM_SCAN:    if (!st.cur_dirty && !st.idx_last) op = OP_SCAN_STEP;
      FSM_WB:      if (st.out_free) op = OP_WB;
      FSM_ZERO:    if (st.out_free) op = OP_ZERO;
      default:     op = OP_NONE;
    endcase
  end

endmodule

[design/crbct_dpath.sv]
module crbct_dpath import crbct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  dp_op_t   op,
  input  logic     out_ready,
  output dp_stat_t st,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  kind_t             kind_r;
  logic [SECT_W-1:0] sector_r;
  logic              mdirty_r;
  logic [CACHE_SLOTS-1:0] match_r;
  logic [CACHE_SLOTS-1:0] vld_r, dty_r, acc_r;
  logic [PIN_W-1:0]  pins_r [CACHE_SLOTS];
  logic [SECT_W-1:0] tag_r  [CACHE_SLOTS];
  logic [IDX_W-1:0]  idx_r, hand_r;
  logic [SECT_W-1:0] rd_sector_r;
  logic              out_valid_r;
  out_rsp_t          out_rsp_r;

  logic [IDX_W-1:0]  hit_idx, free_idx;
  logic [CACHE_SLOTS-1:0] unpinned, vd, above;
  logic              is_flush;

  assign hit_idx  = lowest_set(match_r);
  assign free_idx = lowest_set(~vld_r);
  assign vd       = vld_r & dty_r;
  assign is_flush = (kind_r == KIND_FLUSH);

  always_comb begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      unpinned[i] = (pins_r[i] == '0);
      above[i]    = (IDX_W'(i) > idx_r);
    end
  end

  assign st.is_access    = (kind_r == KIND_ACCESS);
  assign st.in_scan      = (in_req.kind == KIND_WBEHIND) || (in_req.kind == KIND_FLUSH);
  assign st.is_hit       = |match_r;
  assign st.free_any     = ~&vld_r;
  assign st.unpinned_any = |unpinned;
  assign st.sweep_found  = unpinned[idx_r] && !acc_r[idx_r];
  assign st.cur_dirty    = vd[idx_r];
  assign st.idx_last     = (idx_r == IDX_W'(CACHE_SLOTS - 1));
  assign st.more_dirty   = |(vd & above);
  assign st.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // registered sector read of tag_r[idx_r] for write-back
  always_ff @(posedge clk) begin
    rd_sector_r <= tag_r[idx_r];
  end

  logic emit;
  assign emit = (op == OP_HIT) || (op == OP_REL) || (op == OP_FAIL) || (op == OP_FILL) ||
                (op == OP_VICTIM) || (op == OP_WB) || (op == OP_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      dty_r  <= '0;
      acc_r  <= '0;
      hand_r <= '0;
      idx_r  <= '0;
      for (int i = 0; i < CACHE_SLOTS; i++) pins_r[i] <= '0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          kind_r   <= in_req.kind;
          sector_r <= in_req.sector;
          mdirty_r <= in_req.mark_dirty;
          idx_r    <= '0;
        end
        OP_LOOKUP: begin
          for (int i = 0; i < CACHE_SLOTS; i++)
            match_r[i] <= vld_r[i] && (tag_r[i] == sector_r);
        end
        OP_HIT: begin
          acc_r[hit_idx] <= 1'b1;
          dty_r[hit_idx] <= dty_r[hit_idx] | mdirty_r;
          if (pins_r[hit_idx] != PIN_MAX) pins_r[hit_idx] <= pins_r[hit_idx] + 1'b1;
          out_rsp_r <= '{hit: 1'b1, slot: SLOT_W'(hit_idx), fill_needed: 1'b0,
                         writeback_valid: 1'b0, writeback_sector: '0,
                         status: (pins_r[hit_idx] == PIN_MAX) ? ST_PINSAT : ST_OK,
                         last: 1'b1};
        end
        OP_REL: begin
          if (pins_r[hit_idx] != '0) pins_r[hit_idx] <= pins_r[hit_idx] - 1'b1;
          out_rsp_r <= '{hit: 1'b1, slot: SLOT_W'(hit_idx), fill_needed: 1'b0,
                         writeback_valid: 1'b0, writeback_sector: '0,
                         status: ST_OK, last: 1'b1};
        end
        OP_FAIL: begin
          out_rsp_r <= '{hit: 1'b0, slot: '0, fill_needed: 1'b0,
                         writeback_valid: 1'b0, writeback_sector: '0,
                         status: (kind_r == KIND_ACCESS) ? ST_ALLPINNED : ST_UNCACHED,
                         last: 1'b1};
        end
        OP_FILL: begin
          vld_r[free_idx]  <= 1'b1;
          tag_r[free_idx]  <= sector_r;
          acc_r[free_idx]  <= 1'b1;
          pins_r[free_idx] <= PIN_W'(1);
          dty_r[free_idx]  <= mdirty_r;
          out_rsp_r <= '{hit: 1'b0, slot: SLOT_W'(free_idx), fill_needed: 1'b1,
                         writeback_valid: 1'b0, writeback_sector: '0,
                         status: ST_OK, last: 1'b1};
        end
        OP_SWEEP_START: idx_r <= hand_r;
        OP_SWEEP: begin
          // pinned slots are passed over, accessed ones lose their second chance
          if (unpinned[idx_r]) acc_r[idx_r] <= 1'b0;
          idx_r <= wrap_inc(idx_r);
        end
        OP_VICTIM: begin
          tag_r[idx_r]  <= sector_r;
          acc_r[idx_r]  <= 1'b1;
          pins_r[idx_r] <= PIN_W'(1);
          dty_r[idx_r]  <= mdirty_r;
          hand_r        <= wrap_inc(idx_r);
          out_rsp_r <= '{hit: 1'b0, slot: SLOT_W'(idx_r), fill_needed: 1'b1,
                         writeback_valid: dty_r[idx_r],
                         writeback_sector: dty_r[idx_r] ? rd_sector_r : '0,
                         status: ST_OK, last: 1'b1};
        end
        OP_SCAN_STEP: idx_r <= idx_r + 1'b1;
        OP_WB: begin
          idx_r        <= wrap_inc(idx_r);
          out_rsp_r <= '{hit: 1'b0, slot: SLOT_W'(idx_r), fill_needed: 1'b0,
                         writeback_valid: 1'b1, writeback_sector: rd_sector_r,
                         status: ST_OK, last: !st.more_dirty};
          if (!st.more_dirty && is_flush) begin
            vld_r  <= '0;
            dty_r  <= '0;
            acc_r  <= '0;
            hand_r <= '0;
            for (int i = 0; i < CACHE_SLOTS; i++) pins_r[i] <= '0;
          end else begin
            dty_r[idx_r] <= 1'b0;
          end
        end
        OP_ZERO: begin
          out_rsp_r <= '{hit: 1'b0, slot: '0, fill_needed: 1'b0,
                         writeback_valid: 1'b0, writeback_sector: '0,
                         status: ST_OK, last: 1'b1};
          if (is_flush) begin
            vld_r  <= '0;
            dty_r  <= '0;
            acc_r  <= '0;
            hand_r <= '0;
            for (int i = 0; i < CACHE_SLOTS; i++) pins_r[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/clock_replacement_block_cache_tags_unit.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_req  (in_req_t: kind, sector, mark_dirty)
// out     | output    | out_valid / out_ready | out_rsp (out_rsp_t: hit .. last)
//
// Access and release pass accept, tag compare and resolve before the result register loads.
// A miss with every slot in use sweeps the clock hand, visiting at most
// 2*CACHE_SLOTS+1 slots, victim included, and then reads the victim's tag.
// Write-behind and flush step one slot per cycle from slot 0 up to the last dirty
// slot (all slots and one empty result when none is dirty), halting at each dirty slot
// until its report can be loaded. The flush clears all slot state with its last result.
// rst_n is synchronous, active low: all slots invalid, hand at slot 0.
// A stalled out_ready holds the finished result; the next request is taken
// meanwhile and waits only where it needs to load a result.
module clock_replacement_block_cache_tags_unit import crbct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  dp_op_t   op;    // controller command to the slot datapath
  dp_stat_t st;    // lookup, sweep and scan flags back to the controller

  crbct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .in_ready (in_ready),
    .op       (op)
  );

  crbct_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .op        (op),
    .out_ready (out_ready),
    .st        (st),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

[bench/crbct_checker.sv]
module crbct_checker import crbct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_rsp_t out_rsp,
  output int       errors,
  output int       pending
);

  logic             tag_valid [CACHE_SLOTS];
  logic [SECT_W-1:0] tag_sector [CACHE_SLOTS];
  logic             tag_dirty [CACHE_SLOTS];
  logic             tag_ref [CACHE_SLOTS];
  logic [PIN_W-1:0] tag_pins [CACHE_SLOTS];
  logic [IDX_W-1:0] hand;

  out_rsp_t expected_rsps[$];

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      tag_valid[i] = 0; tag_sector[i] = '0; tag_dirty[i] = 0;
      tag_ref[i] = 0; tag_pins[i] = '0;
    end
    hand = '0;
  end

  function automatic out_rsp_t mk_rsp(logic h, logic [IDX_W-1:0] s, logic f, logic w,
                                      logic [SECT_W-1:0] ws, status_t st);
    out_rsp_t r;
    r.hit = h; r.slot = s; r.fill_needed = f; r.writeback_valid = w;
    r.writeback_sector = ws; r.status = st; r.last = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t: mismatch on %s: got %0h expected %0h", $time, what, got, exp);
    errors++;
  endtask

  // Hit search over valid slots only.
  function automatic int find_tag(input logic [SECT_W-1:0] s);
    for (int i = 0; i < CACHE_SLOTS; i++)
      if (tag_valid[i] && tag_sector[i] == s) return i;
    return -1;
  endfunction

  task automatic claim(input int i, input in_req_t r);
    tag_valid[i] = 1; tag_sector[i] = r.sector; tag_ref[i] = 1;
    tag_pins[i] = 1; tag_dirty[i] = r.mark_dirty;
  endtask

  task automatic predict_tags(input in_req_t r);
    int hs, fs, vic, h;
    int n;
    bit any_free;
    out_rsp_t o;
    n = 0;
    case (r.kind)
      KIND_ACCESS: begin
        hs = find_tag(r.sector);
        if (hs >= 0) begin
          tag_ref[hs] = 1;
          tag_dirty[hs] |= r.mark_dirty;
          if (tag_pins[hs] == PIN_MAX) o = mk_rsp(1, IDX_W'(hs), 0, 0, 0, ST_PINSAT);
          else begin
            tag_pins[hs]++;
            o = mk_rsp(1, IDX_W'(hs), 0, 0, 0, ST_OK);
          end
        end else begin
          fs = -1;
          for (int i = CACHE_SLOTS - 1; i >= 0; i--) if (!tag_valid[i]) fs = i;
          if (fs >= 0) begin
            claim(fs, r);
            o = mk_rsp(0, IDX_W'(fs), 1, 0, 0, ST_OK);
          end else begin
            any_free = 0;
            for (int i = 0; i < CACHE_SLOTS; i++) if (tag_pins[i] == 0) any_free = 1;
            vic = -1;
            if (any_free) begin
              h = hand;
              for (int k = 0; k < 2 * CACHE_SLOTS + 1; k++) begin
                if (tag_pins[h] == 0) begin
                  if (tag_ref[h]) tag_ref[h] = 0;
                  else begin
                    vic = h;
                    break;
                  end
                end
                h = (h + 1) % CACHE_SLOTS;
              end
            end
            if (vic < 0) o = mk_rsp(0, 0, 0, 0, 0, ST_ALLPINNED);
            else begin
              o = mk_rsp(0, IDX_W'(vic), 1, tag_dirty[vic],
                         tag_dirty[vic] ? tag_sector[vic] : '0, ST_OK);
              claim(vic, r);
              hand = IDX_W'((vic + 1) % CACHE_SLOTS);
            end
          end
        end
        o.last = 1;
        expected_rsps.push_back(o);
      end
      KIND_RELEASE: begin
        hs = find_tag(r.sector);
        if (hs >= 0) begin
          if (tag_pins[hs] != 0) tag_pins[hs]--;
          o = mk_rsp(1, IDX_W'(hs), 0, 0, 0, ST_OK);
        end else o = mk_rsp(0, 0, 0, 0, 0, ST_UNCACHED);
        o.last = 1;
        expected_rsps.push_back(o);
      end
      default: begin
        // write-behind and flush: one report per dirty slot, ascending, or one empty report if none
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (tag_valid[i] && tag_dirty[i]) begin
            tag_dirty[i] = 0;
            o = mk_rsp(0, IDX_W'(i), 0, 1, tag_sector[i], ST_OK);
            if (n > 0) expected_rsps[$].last = 0;
            o.last = 1;
            expected_rsps.push_back(o);
            n++;
          end
        end
        if (n == 0) begin
          o = mk_rsp(0, 0, 0, 0, 0, ST_OK);
          o.last = 1;
          expected_rsps.push_back(o);
        end
        if (r.kind == KIND_FLUSH) begin
          for (int i = 0; i < CACHE_SLOTS; i++) begin
            tag_valid[i] = 0; tag_dirty[i] = 0; tag_ref[i] = 0; tag_pins[i] = '0;
          end
          hand = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_rsp_t e;
    if (rst_n) begin
      if (in_valid && in_ready) predict_tags(in_req);
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) report("unexpected response", out_rsp, 0);
        else begin
          e = expected_rsps.pop_front();
          if (out_rsp.hit !== e.hit) report("hit", out_rsp.hit, e.hit);
          if (out_rsp.slot !== e.slot) report("slot", out_rsp.slot, e.slot);
          if (out_rsp.fill_needed !== e.fill_needed)
            report("fill_needed", out_rsp.fill_needed, e.fill_needed);
          if (out_rsp.writeback_valid !== e.writeback_valid)
            report("writeback_valid", out_rsp.writeback_valid, e.writeback_valid);
          if (out_rsp.writeback_sector !== e.writeback_sector)
            report("writeback_sector", out_rsp.writeback_sector, e.writeback_sector);
          if (out_rsp.status !== e.status) report("status", out_rsp.status, e.status);
          if (out_rsp.last !== e.last) report("last", out_rsp.last, e.last);
        end
      end
    end
    pending = expected_rsps.size();
  end

endmodule

[bench/clock_replacement_block_cache_tags_unit_tb.sv]
module clock_replacement_block_cache_tags_unit_tb;
  import crbct_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 0;
  out_rsp_t out_rsp;
  int       errors;
  int       pending;

  // request queue built up front, then fed in bursts
  in_req_t  reqs[$];
  bit       stall_on;

  always #6 clk = ~clk;

  clock_replacement_block_cache_tags_unit DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_req, .out_valid, .out_ready, .out_rsp
  );

  crbct_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_req, .out_valid, .out_ready, .out_rsp,
    .errors, .pending
  );

  function automatic in_req_t mk_req(kind_t k, logic [SECT_W-1:0] s, logic d);
    in_req_t r;
    r.kind = k; r.sector = s; r.mark_dirty = d;
    return r;
  endfunction

  // Sectors drawn mostly from a small pool so hits, releases and
  // evictions all happen; the rest spans the full 32-bit range.
  function automatic logic [SECT_W-1:0] pick_sector();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 95);
    return $urandom();
  endfunction

  task automatic build_stimulus();
    in_req_t r;
    // directed: empty write-behind/flush, extreme sectors, release of uncached
    reqs.push_back(mk_req(KIND_WBEHIND, '0, 0));
    reqs.push_back(mk_req(KIND_FLUSH, '1, 1));
    reqs.push_back(mk_req(KIND_RELEASE, 32'h1234, 0));
    reqs.push_back(mk_req(KIND_ACCESS, '0, 1));
    reqs.push_back(mk_req(KIND_ACCESS, '1, 0));
    reqs.push_back(mk_req(KIND_ACCESS, '1, 1));
    reqs.push_back(mk_req(KIND_RELEASE, '1, 0));
    reqs.push_back(mk_req(KIND_RELEASE, '1, 1));
    reqs.push_back(mk_req(KIND_RELEASE, '1, 0));
    reqs.push_back(mk_req(KIND_WBEHIND, '0, 0));
    // fill all 64 slots pinned, then miss: all-pinned error
    for (int i = 0; i < CACHE_SLOTS; i++)
      reqs.push_back(mk_req(KIND_ACCESS, 32'h100 + i, i[0]));
    reqs.push_back(mk_req(KIND_ACCESS, 32'h5555_aaaa, 0));
    // unpin a few, then misses force clock sweeps with dirty victims
    for (int i = 0; i < 6; i++) reqs.push_back(mk_req(KIND_RELEASE, 32'h100 + 2 * i + 1, 0));
    for (int i = 0; i < 4; i++) reqs.push_back(mk_req(KIND_ACCESS, 32'h200 + i, 1));
    reqs.push_back(mk_req(KIND_FLUSH, '0, 0));
    for (int i = 0; i < 164; i++) begin
      case ($urandom_range(0, 19))
        0:       r = mk_req(KIND_FLUSH, $urandom(), 1'($urandom_range(0, 1)));
        1, 2:    r = mk_req(KIND_WBEHIND, $urandom(), 1'($urandom_range(0, 1)));
        3, 4, 5, 6, 7, 8: r = mk_req(KIND_RELEASE, pick_sector(), 1'($urandom_range(0, 1)));
        default: r = mk_req(KIND_ACCESS, pick_sector(), 1'($urandom_range(0, 1)));
      endcase
      reqs.push_back(r);
    end
  endtask

  // receiver: alternates between stall-free stretches and random stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
    out_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  initial begin
    int gap;
    int burst;
    stall_on = 0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (reqs.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && reqs.size() > 0) begin
        in_valid <= 1;
        in_req <= reqs.pop_front();
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst--;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
